/* rtl/core/spat_pkg.sv */
// shared types and constants of the stepper positioner with alarm timers
// no dependencies: every other file in rtl/core uses it by scoped names
package spat_pkg;

  localparam int TRAVEL_W   = 11;
  localparam int INTERVAL_W = 8;
  localparam int POS_W      = 12;
  localparam int FIELD_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam int TIMER_WIDTH_DEFAULT = 16;
  localparam int TIMER_WIDTH_MIN     = 8;
  localparam int TIMER_WIDTH_MAX     = 32;

  localparam logic [TRAVEL_W-1:0]   TRAVEL_RESET   = 11'd512;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd3;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_OPEN_ENTRY = 3'd1,
    CMD_OPEN_EXIT  = 3'd2,
    CMD_CLOSE      = 3'd3,
    CMD_BLINK      = 3'd4,
    CMD_LEDS_OFF   = 3'd5,
    CMD_BUZZ       = 3'd6,
    CMD_GREEN      = 3'd7
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRAVEL   = 1'b0,
    REG_INTERVAL = 1'b1
  } reg_idx_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [FIELD_W-1:0] duration;
    logic [FIELD_W-1:0] flip_gap;
  } item_in_t;

  typedef struct packed {
    logic [3:0]              coils;
    logic                    alarm_led;
    logic                    green_led;
    logic                    buzzer;
    logic                    moving;
    logic signed [POS_W-1:0] position;
  } item_out_t;

  // one accepted item as seen by the state blocks
  typedef struct packed {
    logic fire;
    cmd_e cmd;
  } step_ctl_t;

  typedef struct packed {
    logic [3:0]              coils;
    logic                    moving;
    logic signed [POS_W-1:0] position;
  } motor_stat_t;

  typedef struct packed {
    logic alarm;
    logic green;
    logic buzzer;
  } lamp_stat_t;

  // wave drive, phases 0..3 energize B, A, D, C
  function automatic logic [3:0] wave_coils(input logic [1:0] ph);
    logic [3:0] c;
    case (ph)
      2'd0:    c = 4'b0010;
      2'd1:    c = 4'b0001;
      2'd2:    c = 4'b1000;
      default: c = 4'b0100;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/stepper_positioner_with_alarm_timers_core.sv */
// top level of the stepper positioner with alarm led and buzzer timers
// depends on spat_pkg, spat_motor and spat_lamps
//
// Each input item is a one-millisecond tick or a command; every item gives
// exactly one result item with the coil drive, lamp levels, moving flag and
// tracked position as they stand after that item. An item is accepted
// when in_valid is high and in_stall low, the motor and lamp state
// registers update at that edge and those registers are the result
// register, so out_valid rises in the next cycle. A new item is accepted in
// every cycle as long as the consumer takes results; in_stall only follows
// out_stall while a result is waiting. Motor commands set the target to
// +travel, -travel or 0 and one step is taken every interval ticks
// on the B, A, D, C wave sequence. Configuration writes (cfg_we, cfg_index,
// cfg_data) go to the travel and interval registers and are meant to be made
// while no item is pending. No clearing pass: all state resets at once.
module stepper_positioner_with_alarm_timers_core #(
  parameter int TIMER_WIDTH = spat_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  spat_pkg::item_in_t                  in_data,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output spat_pkg::item_out_t                 out_data,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [spat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spat_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // config registers
  logic [spat_pkg::TRAVEL_W-1:0]   travel;
  logic [spat_pkg::INTERVAL_W-1:0] interval;

  // handshake
  logic                  accept;
  spat_pkg::step_ctl_t   ctl;
  spat_pkg::motor_stat_t motor_stat;
  spat_pkg::lamp_stat_t  lamp_stat;

  // a waiting result blocks new items only while the consumer stalls
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign ctl.fire = accept;
  assign ctl.cmd  = in_data.cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      travel   <= spat_pkg::TRAVEL_RESET;
      interval <= spat_pkg::INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (spat_pkg::reg_idx_e'(cfg_index))
        spat_pkg::REG_TRAVEL:   travel   <= cfg_data[spat_pkg::TRAVEL_W-1:0];
        spat_pkg::REG_INTERVAL: interval <= cfg_data[spat_pkg::INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // result valid: set by an accepted item, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // motor position, step timing and coils
  spat_motor u_motor (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .travel   (travel),
    .interval (interval),
    .stat     (motor_stat)
  );

  // alarm blink, buzzer and green led
  spat_lamps #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_lamps (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .duration (in_data.duration),
    .flip_gap (in_data.flip_gap),
    .stat     (lamp_stat)
  );

  // state registers hold still while a result waits, so they are the payload
  assign out_data.coils     = motor_stat.coils;
  assign out_data.moving    = motor_stat.moving;
  assign out_data.position  = motor_stat.position;
  assign out_data.alarm_led = lamp_stat.alarm;
  assign out_data.green_led = lamp_stat.green;
  assign out_data.buzzer    = lamp_stat.buzzer;

  // wave drive never energizes two coils
  a_coils_onehot0: assert property (@(posedge clk) disable iff (rst)
    $onehot0(out_data.coils))
    else $error("more than one coil energized");

  // coils are released whenever no steps remain
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    !out_data.moving |-> (out_data.coils == 4'b0000))
    else $error("coils driven with no steps left");

  // position only moves when an item is taken
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    (!accept) |=> $stable(out_data.position))
    else $error("position changed without an item");

  // an accepted item always leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item gave no result");

endmodule

/* rtl/core/spat_motor.sv */
// stepper motor state: target diff, step timing, wave phase and position
// depends on spat_pkg
module spat_motor (
  input  logic                               clk,
  input  logic                               rst,
  input  spat_pkg::step_ctl_t                ctl,
  input  logic [spat_pkg::TRAVEL_W-1:0]      travel,
  input  logic [spat_pkg::INTERVAL_W-1:0]    interval,
  output spat_pkg::motor_stat_t              stat
);

  localparam int PW = spat_pkg::POS_W;

  logic [PW-1:0]                     steps_left, steps_left_next;
  logic [spat_pkg::INTERVAL_W-1:0]   step_countdown, step_countdown_next;
  logic [1:0]                        phase, phase_next;
  logic                              reverse, reverse_next;
  logic [PW-1:0]                     motor_pos, motor_pos_next;
  logic [3:0]                        coil_pattern, coil_pattern_next;

  logic signed [PW:0] tgt;
  logic signed [PW:0] diff;
  logic signed [PW:0] neg_diff;
  logic [spat_pkg::INTERVAL_W-1:0] cd_dec;
  logic [1:0]    ph_step;
  logic [PW-1:0] sl_dec;

  always_comb begin
    tgt      = '0;
    diff     = '0;
    neg_diff = '0;
    steps_left_next     = steps_left;
    step_countdown_next = step_countdown;
    phase_next          = phase;
    reverse_next        = reverse;
    motor_pos_next      = motor_pos;
    coil_pattern_next   = coil_pattern;
    cd_dec  = (step_countdown != '0) ? step_countdown - 1'b1 : step_countdown;
    ph_step = reverse ? phase - 2'd1 : phase + 2'd1;
    sl_dec  = steps_left - 1'b1;

    case (ctl.cmd)
      spat_pkg::CMD_OPEN_ENTRY: tgt = $signed({2'b00, travel});
      spat_pkg::CMD_OPEN_EXIT:  tgt = -$signed({2'b00, travel});
      default:                  tgt = '0;
    endcase
    diff     = tgt - $signed({motor_pos[PW-1], motor_pos});
    neg_diff = -diff;

    case (ctl.cmd) inside
      spat_pkg::CMD_TICK: begin
        if (steps_left != '0 && cd_dec == '0) begin
          phase_next          = ph_step;
          motor_pos_next      = reverse ? motor_pos - 1'b1 : motor_pos + 1'b1;
          steps_left_next     = sl_dec;
          step_countdown_next = interval;
          coil_pattern_next   = (sl_dec == '0) ? 4'b0000 : spat_pkg::wave_coils(ph_step);
        end else if (steps_left != '0) begin
          step_countdown_next = cd_dec;
        end
      end
      spat_pkg::CMD_OPEN_ENTRY, spat_pkg::CMD_OPEN_EXIT, spat_pkg::CMD_CLOSE: begin
        if (diff == '0) begin
          // already there: stop and release the coils, direction kept
          steps_left_next     = '0;
          step_countdown_next = '0;
          coil_pattern_next   = 4'b0000;
        end else begin
          reverse_next        = diff[PW];
          steps_left_next     = diff[PW] ? neg_diff[PW-1:0] : diff[PW-1:0];
          step_countdown_next = interval;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left     <= '0;
      step_countdown <= '0;
      phase          <= '0;
      reverse        <= 1'b0;
      motor_pos      <= '0;
      coil_pattern   <= '0;
    end else if (ctl.fire) begin
      steps_left     <= steps_left_next;
      step_countdown <= step_countdown_next;
      phase          <= phase_next;
      reverse        <= reverse_next;
      motor_pos      <= motor_pos_next;
      coil_pattern   <= coil_pattern_next;
    end
  end

  assign stat.coils    = coil_pattern;
  assign stat.moving   = (steps_left != '0);
  assign stat.position = $signed(motor_pos);

endmodule

/* rtl/core/spat_lamps.sv */
// alarm led blink timer, buzzer timer and green led level
// depends on spat_pkg
module spat_lamps #(
  parameter int TIMER_WIDTH = spat_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  spat_pkg::step_ctl_t             ctl,
  input  logic [spat_pkg::FIELD_W-1:0]    duration,
  input  logic [spat_pkg::FIELD_W-1:0]    flip_gap,
  output spat_pkg::lamp_stat_t            stat
);

  logic [TIMER_WIDTH-1:0] blink_remaining, blink_remaining_next;
  logic [TIMER_WIDTH-1:0] blink_period, blink_period_next;
  logic [TIMER_WIDTH-1:0] flip_countdown, flip_countdown_next;
  logic [TIMER_WIDTH-1:0] buzz_remaining, buzz_remaining_next;
  logic alarm, alarm_next;
  logic green, green_next;
  logic buzzer, buzzer_next;

  logic [TIMER_WIDTH-1:0] dur;
  logic [TIMER_WIDTH-1:0] ivl;
  logic [TIMER_WIDTH-1:0] br_dec;
  logic [TIMER_WIDTH-1:0] fc_dec;
  logic [TIMER_WIDTH-1:0] bz_dec;

  always_comb begin
    dur    = TIMER_WIDTH'(duration);
    ivl    = TIMER_WIDTH'(flip_gap);
    br_dec = blink_remaining - TIMER_WIDTH'(1);
    fc_dec = (flip_countdown != '0) ? flip_countdown - TIMER_WIDTH'(1) : flip_countdown;
    bz_dec = buzz_remaining - TIMER_WIDTH'(1);
    blink_remaining_next = blink_remaining;
    blink_period_next    = blink_period;
    flip_countdown_next  = flip_countdown;
    buzz_remaining_next  = buzz_remaining;
    alarm_next  = alarm;
    green_next  = green;
    buzzer_next = buzzer;

    case (ctl.cmd)
      spat_pkg::CMD_TICK: begin
        if (blink_remaining != '0) begin
          blink_remaining_next = br_dec;
          if (fc_dec == '0) begin
            flip_countdown_next = blink_period;
            alarm_next          = ~alarm;
          end else begin
            flip_countdown_next = fc_dec;
          end
          if (br_dec == '0) alarm_next = 1'b0;
        end
        if (buzz_remaining != '0) begin
          buzz_remaining_next = bz_dec;
          buzzer_next         = (bz_dec == '0) ? 1'b0 : ~buzzer;
        end
      end
      spat_pkg::CMD_BLINK: begin
        blink_remaining_next = dur;
        blink_period_next    = ivl;
        flip_countdown_next  = ivl;
        alarm_next           = 1'b1;
      end
      spat_pkg::CMD_LEDS_OFF: begin
        blink_remaining_next = '0;
        alarm_next           = 1'b0;
        green_next           = 1'b0;
      end
      spat_pkg::CMD_BUZZ: begin
        buzz_remaining_next = dur;
        buzzer_next         = 1'b1;
      end
      spat_pkg::CMD_GREEN: green_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_remaining <= '0;
      blink_period    <= '0;
      flip_countdown  <= '0;
      buzz_remaining  <= '0;
      alarm           <= 1'b0;
      green           <= 1'b0;
      buzzer          <= 1'b0;
    end else if (ctl.fire) begin
      blink_remaining <= blink_remaining_next;
      blink_period    <= blink_period_next;
      flip_countdown  <= flip_countdown_next;
      buzz_remaining  <= buzz_remaining_next;
      alarm           <= alarm_next;
      green           <= green_next;
      buzzer          <= buzzer_next;
    end
  end

  assign stat.alarm  = alarm;
  assign stat.green  = green;
  assign stat.buzzer = buzzer;

endmodule
